/* src/assert_macros.svh */
// Assertion helpers shared by the RTL. Each macro samples on i_clk and is
// disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AST_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication.
`define AST_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

/* src/afadj_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afadj_pkg
// Types, constants and fixed-point helpers of the affine adjoint product.
// ----------------------------------------------------------------------------
package afadj_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_W    = 32;
    localparam int DIM       = 6;
    localparam int MAT_N     = DIM * DIM;
    localparam int IDX_W     = 3;
    localparam int NUM_PROD  = 13;
    localparam int NUM_SUM   = 16;

    // Divider width covers 2^(2F) plus half of the largest determinant.
    localparam int DIV_W = ((2 * FRAC_BITS > 62 - FRAC_BITS) ?
                            2 * FRAC_BITS : 62 - FRAC_BITS) + 2;
    localparam int CNT_W = $clog2(DIV_W + 1);

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic signed [63:0]       t_wide;
    typedef t_word                    t_vec [DIM];
    typedef t_word                    t_mat [MAT_N];

    localparam logic [IDX_W-1:0] REG_MAT_A   = 3'd0;
    localparam logic [IDX_W-1:0] REG_MAT_B   = 3'd1;
    localparam logic [IDX_W-1:0] REG_MAT_C   = 3'd2;
    localparam logic [IDX_W-1:0] REG_MAT_D   = 3'd3;
    localparam logic [IDX_W-1:0] REG_SHIFT_X = 3'd4;
    localparam logic [IDX_W-1:0] REG_SHIFT_Y = 3'd5;

    localparam t_wide Q_HALF = 64'sd1 <<< (FRAC_BITS - 1);
    localparam t_word Q_ONE  = t_word'(64'sd1 <<< FRAC_BITS);
    localparam t_word Q_HLF  = t_word'(Q_HALF);
    localparam t_wide MAX64  = 64'sd2147483647;
    localparam t_wide MIN64  = -64'sd2147483648;
    localparam t_word MAXW   = 32'sh7FFF_FFFF;
    localparam t_word MINW   = 32'sh8000_0000;

    typedef enum logic [2:0] {
        MS_DET,
        MS_DIV,
        MS_PROD,
        MS_SUM,
        MS_ENT,
        MS_DONE
    } t_mstate;

    typedef struct packed {
        logic busy;
        logic singular;
        logic ov;
    } t_mat_info;

    // Rounded fixed-point product, half up, floor after the bias.
    function automatic t_wide mulq(t_word p, t_word q);
        t_wide pr;
        pr = t_wide'(p) * t_wide'(q);
        return (pr + Q_HALF) >>> FRAC_BITS;
    endfunction

    function automatic t_wide round_q(t_wide pr);
        return (pr + Q_HALF) >>> FRAC_BITS;
    endfunction

    function automatic logic is_ov(t_wide v);
        return (v > MAX64) || (v < MIN64);
    endfunction

    function automatic t_word sat32(t_wide v);
        t_word r;
        if (v > MAX64) begin
            r = MAXW;
        end else if (v < MIN64) begin
            r = MINW;
        end else begin
            r = t_word'(v);
        end
        return r;
    endfunction

endpackage

/* src/affine2d_adjoint_vector_product.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine2d_adjoint_vector_product
// Product of a six-element tangent vector with the adjoint matrix of a 2D
// affine transform, or with its transpose, in Q16.16 with saturation.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake                 Content
//  cfg      in   i_cfg_we                  register index and data
//  in       in   i_in_valid / o_in_stall   command, vec_0..vec_5
//  out      out  o_out_valid / i_out_stall res_0..res_5, singular, overflow
//
// One beat per cycle is accepted while o_in_stall is low; a result passes the
// input, product, sum and output registers. The input is stalled while the
// matrix sequencer runs after reset and any register write, with a 48-step
// serial reciprocal unless singular or the rounded determinant is zero.
// A held output beat freezes the whole pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module affine2d_adjoint_vector_product (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_command,
    input  logic signed [31:0] i_vec_0,
    input  logic signed [31:0] i_vec_1,
    input  logic signed [31:0] i_vec_2,
    input  logic signed [31:0] i_vec_3,
    input  logic signed [31:0] i_vec_4,
    input  logic signed [31:0] i_vec_5,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic signed [31:0] o_res_0,
    output logic signed [31:0] o_res_1,
    output logic signed [31:0] o_res_2,
    output logic signed [31:0] o_res_3,
    output logic signed [31:0] o_res_4,
    output logic signed [31:0] o_res_5,
    output logic        o_singular,
    output logic        o_overflow
);
    import afadj_pkg::*;

    t_mat      mat;
    t_mat_info info;
    t_vec      vec;
    t_vec      res;

    assign vec[0] = i_vec_0;
    assign vec[1] = i_vec_1;
    assign vec[2] = i_vec_2;
    assign vec[3] = i_vec_3;
    assign vec[4] = i_vec_4;
    assign vec[5] = i_vec_5;

    afadj_mat u_mat (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .o_mat     (mat),
        .o_info    (info)
    );

    afadj_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mat      (mat),
        .i_info     (info),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_command  (i_command),
        .i_vec      (vec),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_res      (res),
        .o_singular (o_singular),
        .o_overflow (o_overflow)
    );

    assign o_res_0 = res[0];
    assign o_res_1 = res[1];
    assign o_res_2 = res[2];
    assign o_res_3 = res[3];
    assign o_res_4 = res[4];
    assign o_res_5 = res[5];

    `AST_NXT(a_cfg_stalls, i_cfg_we, o_in_stall)
    `AST_IMP(a_busy_stalls, info.busy, o_in_stall)
    `AST_IMP(a_sing_no_ovf, o_out_valid && o_singular, !o_overflow)
    `AST_IMP(a_sing_zero, o_out_valid && o_singular, (o_res_0 == 0) && (o_res_5 == 0))

endmodule

/* src/afadj_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afadj_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module afadj_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [afadj_pkg::DIV_W-1:0] i_num,
    input  logic [afadj_pkg::DIV_W-1:0] i_den,
    output logic                       o_done,
    output logic [afadj_pkg::DIV_W-1:0] o_quo
);
    import afadj_pkg::*;

    logic             r_run;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_num;
    logic [DIV_W-1:0] r_den;
    logic [DIV_W-1:0] r_quo;
    logic [DIV_W:0]   n_trial;
    logic             n_fit;

    always_comb begin
        n_trial = {r_rem, r_num[DIV_W-1]};
        n_fit   = n_trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_run  <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_run) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DIV_W - 1)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_num <= i_num;
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_run) begin
            r_num <= {r_num[DIV_W-2:0], 1'b0};
            r_quo <= {r_quo[DIV_W-2:0], n_fit};
            r_rem <= n_fit ? DIV_W'(n_trial - {1'b0, r_den}) : DIV_W'(n_trial);
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

/* src/afadj_mat.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afadj_mat
// Configuration registers and the sequencer that rebuilds the 6x6 adjoint
// matrix after reset and after every register write.
// ----------------------------------------------------------------------------
module afadj_mat (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [afadj_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [afadj_pkg::WORD_W-1:0] i_cfg_data,
    output afadj_pkg::t_mat             o_mat,
    output afadj_pkg::t_mat_info        o_info
);
    import afadj_pkg::*;

    localparam int P_AA = 0, P_AB = 1, P_AC = 2, P_AD = 3, P_BB = 4, P_BC = 5;
    localparam int P_BD = 6, P_CC = 7, P_CD = 8, P_DD = 9, P_FX = 10, P_FY = 11;
    localparam int P_HF = 12;

    t_word   r_a, r_b, r_c, r_d, r_x, r_y;
    t_mstate r_state, n_state;
    logic    r_sing;
    logic    r_neg;
    logic    r_ov;
    t_word   r_f;
    t_word   r_p [NUM_PROD];
    t_word   r_s [NUM_SUM];
    t_mat    r_m;

    t_wide            c_pad, c_pbc, c_det;
    logic             c_sing;
    logic [DIV_W-1:0] c_mag;
    logic [DIV_W-1:0] c_num;
    logic             div_start;
    logic             div_done;
    logic [DIV_W-1:0] div_quo;
    t_word            c_fq;
    logic             c_fq_ov;
    t_wide            c_praw [NUM_PROD];
    t_wide            c_sraw [NUM_SUM];
    t_wide            c_eraw [MAT_N];
    logic             c_p_ov, c_s_ov, c_e_ov;
    logic             busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= Q_ONE;
            r_b <= '0;
            r_c <= '0;
            r_d <= Q_ONE;
            r_x <= '0;
            r_y <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MAT_A:   r_a <= i_cfg_data;
                REG_MAT_B:   r_b <= i_cfg_data;
                REG_MAT_C:   r_c <= i_cfg_data;
                REG_MAT_D:   r_d <= i_cfg_data;
                REG_SHIFT_X: r_x <= i_cfg_data;
                REG_SHIFT_Y: r_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Determinant and the exact singularity test.
    always_comb begin
        c_pad  = t_wide'(r_a) * t_wide'(r_d);
        c_pbc  = t_wide'(r_b) * t_wide'(r_c);
        c_sing = c_pad == c_pbc;
        c_det  = mulq(r_a, r_d) - mulq(r_b, r_c);
        c_mag  = DIV_W'((c_det < 0) ? -c_det : c_det);
        c_num  = DIV_W'(64'd1 << (2 * FRAC_BITS)) + (c_mag >> 1);
    end

    afadj_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (c_num),
        .i_den  (c_mag),
        .o_done (div_done),
        .o_quo  (div_quo)
    );

    // Signed reciprocal from the unsigned quotient, saturated.
    always_comb begin
        c_fq    = '0;
        c_fq_ov = 1'b0;
        if (r_neg) begin
            if (div_quo > DIV_W'(64'd2147483648)) begin
                c_fq    = MINW;
                c_fq_ov = 1'b1;
            end else begin
                c_fq = t_word'(~div_quo[WORD_W-1:0] + 1'b1);
            end
        end else begin
            if (div_quo > DIV_W'(64'd2147483647)) begin
                c_fq    = MAXW;
                c_fq_ov = 1'b1;
            end else begin
                c_fq = t_word'(div_quo[WORD_W-1:0]);
            end
        end
    end

    always_comb begin
        c_praw[P_AA] = mulq(r_a, r_a);
        c_praw[P_AB] = mulq(r_a, r_b);
        c_praw[P_AC] = mulq(r_a, r_c);
        c_praw[P_AD] = mulq(r_a, r_d);
        c_praw[P_BB] = mulq(r_b, r_b);
        c_praw[P_BC] = mulq(r_b, r_c);
        c_praw[P_BD] = mulq(r_b, r_d);
        c_praw[P_CC] = mulq(r_c, r_c);
        c_praw[P_CD] = mulq(r_c, r_d);
        c_praw[P_DD] = mulq(r_d, r_d);
        c_praw[P_FX] = mulq(r_f, r_x);
        c_praw[P_FY] = mulq(r_f, r_y);
        c_praw[P_HF] = mulq(r_f, Q_HLF);
        c_p_ov = 1'b0;
        for (int k = 0; k < NUM_PROD; k++) begin
            c_p_ov = c_p_ov | is_ov(c_praw[k]);
        end
    end

    always_comb begin
        t_wide aa, ab, ac, ad, bb, bc, bd, cc, cd, dd;
        aa = t_wide'(r_p[P_AA]);
        ab = t_wide'(r_p[P_AB]);
        ac = t_wide'(r_p[P_AC]);
        ad = t_wide'(r_p[P_AD]);
        bb = t_wide'(r_p[P_BB]);
        bc = t_wide'(r_p[P_BC]);
        bd = t_wide'(r_p[P_BD]);
        cc = t_wide'(r_p[P_CC]);
        cd = t_wide'(r_p[P_CD]);
        dd = t_wide'(r_p[P_DD]);
        c_sraw[0]  = aa + bb;
        c_sraw[1]  = ac + bd;
        c_sraw[2]  = ab + ab;
        c_sraw[3]  = ad + bc;
        c_sraw[4]  = ac - bd;
        c_sraw[5]  = aa - bb;
        c_sraw[6]  = cc + dd;
        c_sraw[7]  = cd + cd;
        c_sraw[8]  = cc - dd;
        c_sraw[9]  = aa + bb + cc + dd;
        c_sraw[10] = ab + cd;
        c_sraw[11] = bb + dd - aa - cc;
        c_sraw[12] = bd - ac;
        c_sraw[13] = cc + dd - aa - bb;
        c_sraw[14] = cd - ab;
        c_sraw[15] = aa + dd - bb - cc;
        c_s_ov = 1'b0;
        for (int k = 0; k < NUM_SUM; k++) begin
            c_s_ov = c_s_ov | is_ov(c_sraw[k]);
        end
    end

    // Entries of the adjoint; r_s[k] holds the (k+1)-th named sum.
    always_comb begin
        t_word fx, fy, hf;
        fx = r_p[P_FX];
        fy = r_p[P_FY];
        hf = r_p[P_HF];
        for (int k = 0; k < MAT_N; k++) begin
            c_eraw[k] = '0;
        end
        c_eraw[0]  = t_wide'(r_a);
        c_eraw[1]  = t_wide'(r_b);
        c_eraw[2]  = mulq(fy, r_s[0]) - mulq(fx, r_s[1]);
        c_eraw[3]  = -t_wide'(r_x);
        c_eraw[4]  = mulq(fy, r_s[2]) - mulq(fx, r_s[3]);
        c_eraw[5]  = mulq(fx, r_s[4]) - mulq(fy, r_s[5]);
        c_eraw[6]  = t_wide'(r_c);
        c_eraw[7]  = t_wide'(r_d);
        c_eraw[8]  = mulq(fy, r_s[1]) - mulq(fx, r_s[6]);
        c_eraw[9]  = -t_wide'(r_y);
        c_eraw[10] = mulq(fy, r_s[3]) - mulq(fx, r_s[7]);
        c_eraw[11] = mulq(fx, r_s[8]) - mulq(fy, r_s[4]);
        c_eraw[14] = mulq(hf, r_s[9]);
        c_eraw[16] = mulq(r_f, r_s[10]);
        c_eraw[17] = mulq(hf, r_s[11]);
        c_eraw[21] = t_wide'(Q_ONE);
        c_eraw[26] = mulq(r_f, r_s[1]);
        c_eraw[28] = mulq(r_f, r_s[3]);
        c_eraw[29] = mulq(r_f, r_s[12]);
        c_eraw[32] = mulq(hf, r_s[13]);
        c_eraw[34] = mulq(r_f, r_s[14]);
        c_eraw[35] = mulq(hf, r_s[15]);
        c_e_ov = 1'b0;
        for (int k = 0; k < MAT_N; k++) begin
            c_e_ov = c_e_ov | is_ov(c_eraw[k]);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            MS_DET: begin
                if (c_sing) begin
                    n_state = MS_DONE;
                end else if (c_det == 0) begin
                    n_state = MS_PROD;
                end else begin
                    n_state = MS_DIV;
                end
            end
            MS_DIV:  n_state = div_done ? MS_PROD : MS_DIV;
            MS_PROD: n_state = MS_SUM;
            MS_SUM:  n_state = MS_ENT;
            MS_ENT:  n_state = MS_DONE;
            MS_DONE: n_state = MS_DONE;
            default: n_state = MS_DET;
        endcase
        if (i_cfg_we) begin
            n_state = MS_DET;
        end
    end

    always_comb begin
        busy      = r_state != MS_DONE;
        div_start = (r_state == MS_DET) && !i_cfg_we && !c_sing && (c_det != 0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MS_DET;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            MS_DET: begin
                r_sing <= c_sing;
                r_neg  <= c_det < 0;
                r_ov   <= !c_sing && (c_det == 0);
                r_f    <= (c_pad > c_pbc) ? MAXW : MINW;
            end
            MS_DIV: begin
                if (div_done) begin
                    r_f  <= c_fq;
                    r_ov <= r_ov | c_fq_ov;
                end
            end
            MS_PROD: begin
                for (int k = 0; k < NUM_PROD; k++) begin
                    r_p[k] <= sat32(c_praw[k]);
                end
                r_ov <= r_ov | c_p_ov;
            end
            MS_SUM: begin
                for (int k = 0; k < NUM_SUM; k++) begin
                    r_s[k] <= sat32(c_sraw[k]);
                end
                r_ov <= r_ov | c_s_ov;
            end
            MS_ENT: begin
                for (int k = 0; k < MAT_N; k++) begin
                    r_m[k] <= sat32(c_eraw[k]);
                end
                r_ov <= r_ov | c_e_ov;
            end
            default: ;
        endcase
    end

    assign o_mat         = r_m;
    assign o_info.busy     = busy;
    assign o_info.singular = r_sing;
    assign o_info.ov       = r_ov;

endmodule

/* src/afadj_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afadj_dp
// Four-stage product pipeline: input register, 36 products, rounded row
// sums, saturation into the output register.
// ----------------------------------------------------------------------------
module afadj_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  afadj_pkg::t_mat       i_mat,
    input  afadj_pkg::t_mat_info  i_info,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_command,
    input  afadj_pkg::t_vec       i_vec,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output afadj_pkg::t_vec       o_res,
    output logic                  o_singular,
    output logic                  o_overflow
);
    import afadj_pkg::*;

    logic  r_v0, r_v1, r_v2, r_v3;
    logic  r_cmd;
    t_vec  r_vec;
    t_wide r_prod [MAT_N];
    t_wide r_acc  [DIM];
    t_vec  r_res;
    logic  r_sing, r_ovf;
    logic  en, accept;
    t_wide c_acc [DIM];
    t_vec  c_res;
    logic  c_ovf;

    // Whole pipe advances unless the output beat is held.
    assign en         = !(r_v3 && i_out_stall);
    assign accept     = i_in_valid && en && !i_info.busy;
    assign o_in_stall = !en || i_info.busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v0 <= accept;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_comb begin
        for (int i = 0; i < DIM; i++) begin
            c_acc[i] = '0;
            for (int j = 0; j < DIM; j++) begin
                c_acc[i] = c_acc[i] + round_q(r_prod[i*DIM+j]);
            end
        end
        c_ovf = 1'b0;
        for (int i = 0; i < DIM; i++) begin
            c_res[i] = sat32(r_acc[i]);
            c_ovf    = c_ovf | is_ov(r_acc[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (accept) begin
                r_cmd <= i_command;
                r_vec <= i_vec;
            end
            // Slot j of row i always multiplies element j of the vector.
            for (int i = 0; i < DIM; i++) begin
                for (int j = 0; j < DIM; j++) begin
                    r_prod[i*DIM+j] <= t_wide'(r_cmd ? i_mat[j*DIM+i] : i_mat[i*DIM+j])
                                       * t_wide'(r_vec[j]);
                end
            end
            r_acc <= c_acc;
            if (i_info.singular) begin
                for (int i = 0; i < DIM; i++) begin
                    r_res[i] <= '0;
                end
                r_sing <= 1'b1;
                r_ovf  <= 1'b0;
            end else begin
                r_res  <= c_res;
                r_sing <= 1'b0;
                r_ovf  <= c_ovf | i_info.ov;
            end
        end
    end

    assign o_out_valid = r_v3;
    assign o_res       = r_res;
    assign o_singular  = r_sing;
    assign o_overflow  = r_ovf;

endmodule

/* tb/tb_affine2d_adjoint_vector_product.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_affine2d_adjoint_vector_product
// Drives tangent vectors through the affine adjoint product under a series of
// transform settings. A bit-exact fixed-point model predicts each output beat,
// and a scoreboard compares every field of every beat in order. Both channels
// idle and stall at random, and the output is held off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_affine2d_adjoint_vector_product;
    import afadj_pkg::*;

    localparam logic        CMD_ADJOINT   = 1'b0;
    localparam logic        CMD_TRANSPOSE = 1'b1;
    localparam logic [2:0]  REG_SPARE_LO  = 3'd6;
    localparam logic [2:0]  REG_SPARE_HI  = 3'd7;
    localparam longint      SAT_HI        = 64'sd2147483647;
    localparam longint      SAT_LO        = -64'sd2147483648;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          HOLD_BEAT     = 400;
    localparam int          HOLD_CYCLES   = 200;

    typedef struct packed {
        logic [5:0][31:0] res;
        logic             singular;
        logic             overflow;
    } t_adj_beat;

    // Fixed-point model of the block plus the queue of beats still owed.
    class adjoint_scoreboard;
        longint    ra, rb, rc, rd, rsx, rsy;
        bit        ovf;
        t_adj_beat owed[$];
        int        mismatches;

        function new();
            ra = 64'sd1 <<< FRAC_BITS;
            rb = 0;
            rc = 0;
            rd = 64'sd1 <<< FRAC_BITS;
            rsx = 0;
            rsy = 0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] data);
            longint v;
            v = longint'($signed(data));
            case (idx)
                REG_MAT_A:   ra = v;
                REG_MAT_B:   rb = v;
                REG_MAT_C:   rc = v;
                REG_MAT_D:   rd = v;
                REG_SHIFT_X: rsx = v;
                REG_SHIFT_Y: rsy = v;
                default: ;
            endcase
        endfunction

        function longint mq(longint p, longint q);
            longint w;
            w = p * q + (64'sd1 <<< (FRAC_BITS - 1));
            return w >>> FRAC_BITS;
        endfunction

        function longint clip(longint v);
            if (v > SAT_HI) begin
                ovf = 1;
                return SAT_HI;
            end
            if (v < SAT_LO) begin
                ovf = 1;
                return SAT_LO;
            end
            return v;
        endfunction

        // Computes the expected beat for an accepted input and queues it.
        function void note_input(logic cmd, t_vec vec);
            longint    m[36];
            longint    det, f, mag, q, acc, e;
            longint    aa, ab, ac, ad, bb, bc, bd, cc, cd, dd, fx, fy, hf;
            longint    s1, s2, s3, s4, s5, s6, s7, s8, s9, s10, s11, s12, s13,
                       s14, s15, s16;
            t_adj_beat exp_beat;
            exp_beat = '0;
            ovf = 0;
            if (ra * rd == rb * rc) begin
                exp_beat.singular = 1'b1;
                owed.push_back(exp_beat);
                return;
            end
            det = mq(ra, rd) - mq(rb, rc);
            if (det == 0) begin
                // Exact determinant nonzero but rounded away.
                ovf = 1;
                f = (ra * rd > rb * rc) ? SAT_HI : SAT_LO;
            end else begin
                mag = (det < 0) ? -det : det;
                q = ((64'sd1 <<< (2 * FRAC_BITS)) + mag / 2) / mag;
                f = clip((det < 0) ? -q : q);
            end
            aa = clip(mq(ra, ra)); ab = clip(mq(ra, rb));
            ac = clip(mq(ra, rc)); ad = clip(mq(ra, rd));
            bb = clip(mq(rb, rb)); bc = clip(mq(rb, rc));
            bd = clip(mq(rb, rd)); cc = clip(mq(rc, rc));
            cd = clip(mq(rc, rd)); dd = clip(mq(rd, rd));
            fx = clip(mq(f, rsx)); fy = clip(mq(f, rsy));
            hf = clip(mq(f, 64'sd1 <<< (FRAC_BITS - 1)));
            s1 = clip(aa + bb); s2 = clip(ac + bd);
            s3 = clip(ab + ab); s4 = clip(ad + bc);
            s5 = clip(ac - bd); s6 = clip(aa - bb);
            s7 = clip(cc + dd); s8 = clip(cd + cd);
            s9 = clip(cc - dd); s10 = clip(aa + bb + cc + dd);
            s11 = clip(ab + cd); s12 = clip(bb + dd - aa - cc);
            s13 = clip(bd - ac); s14 = clip(cc + dd - aa - bb);
            s15 = clip(cd - ab); s16 = clip(aa + dd - bb - cc);
            foreach (m[k]) m[k] = 0;
            m[0] = ra;
            m[1] = rb;
            m[2] = clip(mq(fy, s1) - mq(fx, s2));
            m[3] = clip(-rsx);
            m[4] = clip(mq(fy, s3) - mq(fx, s4));
            m[5] = clip(mq(fx, s5) - mq(fy, s6));
            m[6] = rc;
            m[7] = rd;
            m[8] = clip(mq(fy, s2) - mq(fx, s7));
            m[9] = clip(-rsy);
            m[10] = clip(mq(fy, s4) - mq(fx, s8));
            m[11] = clip(mq(fx, s9) - mq(fy, s5));
            m[14] = clip(mq(hf, s10));
            m[16] = clip(mq(f, s11));
            m[17] = clip(mq(hf, s12));
            m[21] = 64'sd1 <<< FRAC_BITS;
            m[26] = clip(mq(f, s2));
            m[28] = clip(mq(f, s4));
            m[29] = clip(mq(f, s13));
            m[32] = clip(mq(hf, s14));
            m[34] = clip(mq(f, s15));
            m[35] = clip(mq(hf, s16));
            for (int i = 0; i < DIM; i++) begin
                acc = 0;
                for (int j = 0; j < DIM; j++) begin
                    e = (cmd == CMD_TRANSPOSE) ? m[j * DIM + i] : m[i * DIM + j];
                    acc += mq(e, longint'(vec[j]));
                end
                exp_beat.res[i] = 32'(clip(acc));
            end
            exp_beat.overflow = ovf;
            owed.push_back(exp_beat);
        endfunction

        function void check_result(t_adj_beat got);
            t_adj_beat want;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected output beat %h", got);
                return;
            end
            want = owed.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: output beat mismatch at %0t", $realtime);
                    for (int i = 0; i < DIM; i++)
                        $display("  res_%0d expected %h actual %h", i,
                                 want.res[i], got.res[i]);
                    $display("  singular expected %b actual %b",
                             want.singular, got.singular);
                    $display("  overflow expected %b actual %b",
                             want.overflow, got.overflow);
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_command;
    logic signed [31:0] i_vec_0, i_vec_1, i_vec_2, i_vec_3, i_vec_4, i_vec_5;
    logic        o_out_valid;
    logic        i_out_stall;
    logic signed [31:0] o_res_0, o_res_1, o_res_2, o_res_3, o_res_4, o_res_5;
    logic        o_singular;
    logic        o_overflow;

    adjoint_scoreboard sb;
    int  cycles = 0;
    bit  no_idle;
    int  beats_out;

    affine2d_adjoint_vector_product dut (.*);

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("affine2d_adjoint_vector_product verification failed");
            $finish;
        end
    end

    // Output monitor; samples pre-edge values.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result({o_res_5, o_res_4, o_res_3, o_res_2, o_res_1, o_res_0,
                             o_singular, o_overflow});
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 6))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            3: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 8);
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits for the pipeline to drain so the registers can change safely.
    task automatic wait_drained();
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_transform(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                 logic [31:0] d, logic [31:0] sx, logic [31:0] sy);
        wait_drained();
        write_reg(REG_MAT_A, a);
        write_reg(REG_MAT_B, b);
        write_reg(REG_MAT_C, c);
        write_reg(REG_MAT_D, d);
        write_reg(REG_SHIFT_X, sx);
        write_reg(REG_SHIFT_Y, sy);
    endtask

    // Leaves valid high after the beat so back-to-back beats need no toggle.
    task automatic send_vector(logic cmd, t_vec v);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_vec_0 <= v[0]; i_vec_1 <= v[1]; i_vec_2 <= v[2];
        i_vec_3 <= v[3]; i_vec_4 <= v[4]; i_vec_5 <= v[5];
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(cmd, v);
    endtask

    task automatic run_random(int n);
        t_vec v;
        for (int k = 0; k < n; k++) begin
            foreach (v[i]) v[i] = rand_word();
            send_vector(logic'($urandom_range(0, 1)), v);
        end
        i_in_valid <= 1'b0;
    endtask

    task automatic run_directed();
        t_vec v;
        logic [31:0] pick[5];
        pick = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000};
        for (int p = 0; p < 5; p++) begin
            foreach (v[i]) v[i] = pick[p];
            send_vector(CMD_ADJOINT, v);
            send_vector(CMD_TRANSPOSE, v);
        end
        // One-hot unit vectors pick out single columns and rows.
        for (int i = 0; i < DIM; i++) begin
            foreach (v[j]) v[j] = (i == j) ? 32'h0001_0000 : 32'h0;
            send_vector(CMD_ADJOINT, v);
            send_vector(CMD_TRANSPOSE, v);
        end
        i_in_valid <= 1'b0;
    endtask

    // Receiver: random stall before each beat and one long hold-off.
    initial begin
        int w;
        bit held;
        held = 0;
        beats_out = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (!held && beats_out >= HOLD_BEAT) begin
                held = 1;
                w = HOLD_CYCLES;
            end else begin
                w = draw_gap();
            end
            if (w > 0) begin
                i_out_stall <= 1'b1;
                repeat (w) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
            beats_out++;
        end
    end

    initial begin
        sb = new();
        no_idle = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_MAT_A;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_command = CMD_ADJOINT;
        i_vec_0 = '0; i_vec_1 = '0; i_vec_2 = '0;
        i_vec_3 = '0; i_vec_4 = '0; i_vec_5 = '0;
        i_out_stall = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset transform is the identity.
        run_directed();
        run_random(40);

        set_transform(32'h0001_8000, 32'hFFFF_4000, 32'h0000_6000, 32'h0002_0000,
                      32'h0003_0000, 32'hFFFE_8000);
        run_directed();
        // Writes to unused indexes must leave the transform alone.
        wait_drained();
        write_reg(REG_SPARE_LO, 32'hDEAD_BEEF);
        write_reg(REG_SPARE_HI, 32'h1234_5678);
        no_idle = 1;
        run_random(60);
        no_idle = 0;

        // Singular matrix.
        set_transform(32'h0001_0000, 32'h0002_0000, 32'h0002_0000, 32'h0004_0000,
                      32'h0001_0000, 32'h0001_0000);
        run_random(30);

        // Tiny determinant rounds to zero.
        set_transform(32'h0000_0001, 32'h0, 32'h0, 32'h0000_0001,
                      32'h0000_0100, 32'hFFFF_FF00);
        run_random(30);
        set_transform(32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
        run_random(20);

        // Most negative shifts.
        set_transform(32'h0000_8000, 32'h0, 32'h0, 32'h0000_8000,
                      32'h8000_0000, 32'h8000_0000);
        run_random(40);

        // Extreme matrix entries.
        set_transform(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 32'h8000_0000);
        run_random(40);
        set_transform(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF);
        run_random(20);

        // Long phase that spans the receiver hold-off.
        set_transform(32'h0000_C000, 32'h0000_2000, 32'hFFFF_E000, 32'h0001_4000,
                      32'h0000_4000, 32'h0000_8000);
        no_idle = 1;
        run_random(60);
        no_idle = 0;
        run_random(140);

        for (int r = 0; r < 12; r++) begin
            set_transform(rand_word(), rand_word(), rand_word(), rand_word(),
                          rand_word(), rand_word());
            no_idle = (r % 4 == 3);
            run_random(40);
        end
        no_idle = 0;

        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.owed.size() == 0) begin
            $display("affine2d_adjoint_vector_product verification clean");
        end else begin
            $display("affine2d_adjoint_vector_product verification failed");
        end
        $finish;
    end

endmodule
